@@ sv/subset_rank_unrank_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the subset rank/unrank block
// Implication checks on the block clock with reset masking.
// ---------------------------------------------------------------------------
`ifndef SUBSET_RANK_UNRANK_ASSERT_SVH
`define SUBSET_RANK_UNRANK_ASSERT_SVH

// Same-cycle implication.
`define SRU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sru_pkg.sv @@
// ---------------------------------------------------------------------------
// sru_pkg
// Widths, defaults and codes shared by the subset rank/unrank block.
// ---------------------------------------------------------------------------
package sru_pkg;

    localparam int UNIVERSE_W = 7;
    localparam int SUBSET_W   = 5;
    localparam int CNT_W      = 7;
    localparam int MASK_W     = 64;
    localparam int RANK_W     = 32;
    localparam int COEF_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int DEF_MAX_UNIVERSE = 64;
    localparam int DEF_MAX_SUBSET   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSET   = 1'd1;

    localparam logic MODE_RANK   = 1'b0;
    localparam logic MODE_UNRANK = 1'b1;

endpackage

@@ sv/sru_coef_mem.sv @@
// ---------------------------------------------------------------------------
// sru_coef_mem
// Binomial coefficient memory, built row by row after reset, two read ports.
// ---------------------------------------------------------------------------
module sru_coef_mem #(
    parameter int MAX_UNIVERSE = sru_pkg::DEF_MAX_UNIVERSE,
    parameter int MAX_SUBSET   = sru_pkg::DEF_MAX_SUBSET
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    output logic                                   ready,
    input  logic [$clog2(MAX_UNIVERSE+1)+$clog2(MAX_SUBSET+1)-1:0] rd_addr_a,
    input  logic [$clog2(MAX_UNIVERSE+1)+$clog2(MAX_SUBSET+1)-1:0] rd_addr_b,
    output logic [sru_pkg::COEF_W-1:0]             rd_data_a,
    output logic [sru_pkg::COEF_W-1:0]             rd_data_b
);
    import sru_pkg::*;

    localparam int NW    = $clog2(MAX_UNIVERSE + 1);
    localparam int RW    = $clog2(MAX_SUBSET + 1);
    localparam int AW    = NW + RW;
    localparam int DEPTH = 1 << AW;

    logic [COEF_W-1:0] coef_mem [DEPTH];

    logic              issue_reg;
    logic [NW-1:0]     fn_reg;
    logic [RW-1:0]     fr_reg;
    logic              wr_pend_reg;
    logic [NW-1:0]     wr_n_reg;
    logic [RW-1:0]     wr_r_reg;
    logic [COEF_W-1:0] prev_reg;
    logic              ready_reg;
    logic [COEF_W-1:0] rd_data_a_reg;
    logic [COEF_W-1:0] rd_data_b_reg;

    logic [AW-1:0]     addr_a;
    logic [COEF_W-1:0] wr_data;

    // Row n entry r is row n-1 entry r plus row n-1 entry r-1 (held in prev_reg).
    always_comb
    begin
        addr_a = ready_reg ? rd_addr_a : {fn_reg - NW'(1), fr_reg};
        if (wr_n_reg == '0)
        begin
            wr_data = (wr_r_reg == '0) ? COEF_W'(1) : '0;
        end
        else
        begin
            wr_data = rd_data_a_reg + ((wr_r_reg == '0) ? '0 : prev_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= 1'b1;
            fn_reg      <= '0;
            fr_reg      <= '0;
            wr_pend_reg <= 1'b0;
            wr_n_reg    <= '0;
            wr_r_reg    <= '0;
            prev_reg    <= '0;
            ready_reg   <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= issue_reg;
            if (issue_reg)
            begin
                wr_n_reg <= fn_reg;
                wr_r_reg <= fr_reg;
                if (fr_reg == RW'(MAX_SUBSET))
                begin
                    fr_reg <= '0;
                    if (fn_reg == NW'(MAX_UNIVERSE))
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        fn_reg <= fn_reg + NW'(1);
                    end
                end
                else
                begin
                    fr_reg <= fr_reg + RW'(1);
                end
            end
            if (wr_pend_reg)
            begin
                prev_reg <= rd_data_a_reg;
                if (!issue_reg)
                begin
                    ready_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            coef_mem[{wr_n_reg, wr_r_reg}] <= wr_data;
        end
        rd_data_a_reg <= coef_mem[addr_a];
        rd_data_b_reg <= coef_mem[rd_addr_b];
    end

    assign ready     = ready_reg;
    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

@@ sv/subset_rank_unrank.sv @@
// ---------------------------------------------------------------------------
// subset_rank_unrank
// Colex rank/unrank of k-subsets in the combinatorial number system.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  config    cfg_we                 cfg_index, cfg_data
//  input     in_valid / in_ready    mode, mask_in, rank_in
//  output    out_valid / out_ready  rank_out, mask_out, error
//
//  Rank and unrank items are both carried out by a walk that reads one
//  coefficient per cycle (unrank fetches two candidates) from the
//  coefficient memory, whose read is registered.
//  After reset the memory is built row by row; no item is taken then.
//  A finished result sits in the output register; the next item is accepted
//  while it waits, and the walk only stalls at its end if it is still held.
// ---------------------------------------------------------------------------
module subset_rank_unrank #(
    parameter int MAX_UNIVERSE = sru_pkg::DEF_MAX_UNIVERSE,
    parameter int MAX_SUBSET   = sru_pkg::DEF_MAX_SUBSET
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sru_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic [sru_pkg::MASK_W-1:0]       mask_in,
    input  logic [sru_pkg::RANK_W-1:0]       rank_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sru_pkg::RANK_W-1:0]       rank_out,
    output logic [sru_pkg::MASK_W-1:0]       mask_out,
    output logic                             error
);
    import sru_pkg::*;

    `include "subset_rank_unrank_assert.svh"

    localparam int NW = $clog2(MAX_UNIVERSE + 1);
    localparam int RW = $clog2(MAX_SUBSET + 1);
    localparam int AW = NW + RW;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_RANK,
        S_RDRAIN,
        S_USTART,
        S_UNRANK,
        S_DONE
    } state_t;

    // Configuration registers
    logic [UNIVERSE_W-1:0] universe_reg;
    logic [SUBSET_W-1:0]   subset_reg;

    // Walk state
    state_t              state_reg, state_next;
    logic                mode_reg, mode_next;
    logic                err_reg, err_next;
    logic                first_reg, first_next;
    logic                hit_prev_reg, hit_prev_next;
    logic                acc_pend_reg, acc_pend_next;
    logic [NW-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUBSET_W-1:0] e_reg, e_next;
    logic [RANK_W-1:0]   rem_reg, rem_next;
    logic [COEF_W-1:0]   sum_reg, sum_next;
    logic [MASK_W-1:0]   mask_reg, mask_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [RANK_W-1:0]   rank_out_reg, rank_out_next;
    logic [MASK_W-1:0]   mask_out_reg, mask_out_next;
    logic                err_out_reg, err_out_next;

    logic                mem_ready;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    logic [COEF_W-1:0]   rd_data_a;
    logic [COEF_W-1:0]   rd_data_b;

    logic                cfg_bad;
    logic [NW-1:0]       v_n;
    logic [NW-1:0]       v1_n;
    logic [RW-1:0]       k_r;
    logic [COEF_W-1:0]   coef_sel;
    logic                hit;
    logic                rank_fail;

    sru_coef_mem #(
        .MAX_UNIVERSE (MAX_UNIVERSE),
        .MAX_SUBSET   (MAX_SUBSET)
    ) u_coef_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ready     (mem_ready),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Take configuration writes at any time; software must write them only idle, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            universe_reg <= UNIVERSE_W'(7);
            subset_reg   <= SUBSET_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_UNIVERSE: universe_reg <= cfg_data[UNIVERSE_W-1:0];
                CFG_SUBSET:   subset_reg   <= cfg_data[SUBSET_W-1:0];
                default:      ;
            endcase
        end
    end

    // A configuration outside the supported range fails every item at once.
    assign cfg_bad = (universe_reg < UNIVERSE_W'(2))
                  || (int'(universe_reg) > MAX_UNIVERSE)
                  || (subset_reg == '0)
                  || (int'(subset_reg) > MAX_SUBSET)
                  || (UNIVERSE_W'(subset_reg) >= universe_reg);

    // These truncations are exact whenever the configuration is good.
    assign v_n  = NW'(universe_reg);
    assign v1_n = NW'(universe_reg - UNIVERSE_W'(1));
    assign k_r  = RW'(subset_reg);

    // Unrank compares against C(pos, e+1). Both candidates for the next
    // position are fetched: port A keeps e, port B serves e-1 after a hit.
    assign coef_sel  = hit_prev_reg ? rd_data_b : rd_data_a;
    assign hit       = coef_sel <= COEF_W'(rem_reg);
    assign rank_fail = err_reg || (cnt_reg != CNT_W'(subset_reg))
                    || (sum_reg[COEF_W-1:RANK_W] != '0);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        err_next       = err_reg;
        first_next     = first_reg;
        hit_prev_next  = hit_prev_reg;
        acc_pend_next  = acc_pend_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        e_next         = e_reg;
        rem_next       = rem_reg;
        sum_next       = sum_reg;
        mask_next      = mask_reg;
        out_valid_next = out_valid_reg;
        rank_out_next  = rank_out_reg;
        mask_out_next  = mask_out_reg;
        err_out_next   = err_out_reg;
        rd_addr_a      = {v_n, k_r};
        rd_addr_b      = {v1_n, k_r};

        // Drop the result once the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_FILL:
            begin
                if (mem_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next     = mode;
                    err_next      = cfg_bad;
                    first_next    = 1'b1;
                    hit_prev_next = 1'b1;
                    acc_pend_next = 1'b0;
                    cnt_next      = '0;
                    e_next        = subset_reg - SUBSET_W'(1);
                    rem_next      = rank_in;
                    sum_next      = '0;
                    if (mode == MODE_RANK)
                    begin
                        pos_next  = '0;
                        mask_next = mask_in;
                    end
                    else
                    begin
                        pos_next  = v1_n;
                        mask_next = '0;
                    end
                    if (cfg_bad)
                    begin
                        state_next = S_DONE;
                    end
                    else if (mode == MODE_RANK)
                    begin
                        state_next = S_RANK;
                    end
                    else
                    begin
                        state_next = S_USTART;
                    end
                end
            end

            S_RANK:
            begin
                // Fetch C(pos, cnt+1) for a set bit among the first k;
                // add the previous fetch, advance one position.
                rd_addr_a     = {pos_reg, RW'(cnt_reg + CNT_W'(1))};
                acc_pend_next = 1'b0;
                if (acc_pend_reg)
                begin
                    sum_next = sum_reg + rd_data_a;
                end
                if (mask_reg[0])
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (cnt_reg < CNT_W'(subset_reg))
                    begin
                        acc_pend_next = 1'b1;
                    end
                end
                mask_next = mask_reg >> 1;
                pos_next  = pos_reg + NW'(1);
                if (pos_reg == v1_n)
                begin
                    state_next = S_RDRAIN;
                end
            end

            S_RDRAIN:
            begin
                if (acc_pend_reg)
                begin
                    sum_next = sum_reg + rd_data_a;
                end
                acc_pend_next = 1'b0;
                state_next    = S_DONE;
            end

            S_USTART:
            begin
                // Default addresses fetch C(v,k) and C(v-1,k).
                state_next = S_UNRANK;
            end

            S_UNRANK:
            begin
                rd_addr_a = {pos_reg - NW'(1), RW'(e_reg + SUBSET_W'(1))};
                rd_addr_b = {pos_reg - NW'(1), RW'(e_reg)};
                if (first_reg && (COEF_W'(rem_reg) >= rd_data_a))
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    first_next    = 1'b0;
                    hit_prev_next = hit;
                    pos_next      = pos_reg - NW'(1);
                    if (hit)
                    begin
                        mask_next = mask_reg | (MASK_W'(1) << pos_reg);
                        rem_next  = rem_reg - coef_sel[RANK_W-1:0];
                        if (e_reg == '0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            e_next = e_reg - SUBSET_W'(1);
                        end
                    end
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg == MODE_RANK)
                    begin
                        rank_out_next = rank_fail ? '0 : sum_reg[RANK_W-1:0];
                        mask_out_next = '0;
                        err_out_next  = rank_fail;
                    end
                    else
                    begin
                        rank_out_next = '0;
                        mask_out_next = err_reg ? '0 : mask_reg;
                        err_out_next  = err_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            mode_reg      <= MODE_RANK;
            err_reg       <= 1'b0;
            first_reg     <= 1'b0;
            hit_prev_reg  <= 1'b0;
            acc_pend_reg  <= 1'b0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            e_reg         <= '0;
            rem_reg       <= '0;
            sum_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            rank_out_reg  <= '0;
            mask_out_reg  <= '0;
            err_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            err_reg       <= err_next;
            first_reg     <= first_next;
            hit_prev_reg  <= hit_prev_next;
            acc_pend_reg  <= acc_pend_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            e_reg         <= e_next;
            rem_reg       <= rem_next;
            sum_reg       <= sum_next;
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
            rank_out_reg  <= rank_out_next;
            mask_out_reg  <= mask_out_next;
            err_out_reg   <= err_out_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rank_out  = rank_out_reg;
    assign mask_out  = mask_out_reg;
    assign error     = err_out_reg;

    `SRU_ASSERT_IMPL(a_fill_before_accept, in_ready, mem_ready, "item taken before coefficient fill")
    `SRU_ASSERT_IMPL(a_rank_fetch_count, acc_pend_reg, cnt_reg <= CNT_W'(subset_reg), "coefficient fetched past k-th bit")
    `SRU_ASSERT_IMPL(a_unrank_bits, state_reg == S_UNRANK, $countones(mask_reg) + int'(e_reg) + 1 == int'(subset_reg), "decoded bit count out of step with element index")
    `SRU_ASSERT_NEXT(a_done_loads_out, (state_reg == S_DONE) && (!out_valid_reg || out_ready), out_valid_reg && (state_reg == S_IDLE), "finished item not loaded into output register")

endmodule

@@ tb/subset_rank_unrank_checker.sv @@
// ---------------------------------------------------------------------------
// subset_rank_unrank_checker
// Watches the config port and both item channels of the subset rank/unrank
// block. Predicts each result from its own binomial table and register copy
// and compares the results in order.
// ---------------------------------------------------------------------------
module subset_rank_unrank_checker
    import sru_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic                   mode,
    input  logic [MASK_W-1:0]      mask_in,
    input  logic [RANK_W-1:0]      rank_in,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [RANK_W-1:0]      rank_out,
    input  logic [MASK_W-1:0]      mask_out,
    input  logic                   error,
    output int                     mismatches,
    output int                     outstanding,
    output int                     checked,
    output int                     flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_N = DEF_MAX_UNIVERSE;
    localparam int TOP_R = DEF_MAX_SUBSET + 1;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [MASK_W-1:0] mask;
        logic              err;
    } colex_result_t;

    logic [COEF_W-1:0]     pascal [0:TOP_N][0:TOP_R];
    logic [UNIVERSE_W-1:0] shadow_v;
    logic [SUBSET_W-1:0]   shadow_k;
    colex_result_t         due_results [$];
    int                    fail_total = 0;
    int                    seen_total = 0;
    int                    flag_total = 0;

    assign mismatches = fail_total;
    assign checked    = seen_total;
    assign flagged    = flag_total;

    initial
    begin : build_pascal
        for (int n = 0; n <= TOP_N; n++)
        begin
            pascal[n][0] = 64'd1;
            for (int r = 1; r <= TOP_R; r++)
                pascal[n][r] = (n == 0) ? 64'd0 : pascal[n-1][r-1] + pascal[n-1][r];
        end
    end

    // Colex rank of a mask, or the mask of a colex rank.
    function automatic colex_result_t colex_convert(input logic [UNIVERSE_W-1:0] v,
                                                    input logic [SUBSET_W-1:0] k,
                                                    input logic md,
                                                    input logic [MASK_W-1:0] msk,
                                                    input logic [RANK_W-1:0] rnk);
        colex_result_t r;
        logic [COEF_W-1:0] acc;
        logic [COEF_W-1:0] rem;
        int nv;
        int nk;
        int cnt;
        int pos;
        int e;
        int p;
        r = '0;
        nv = v;
        nk = k;
        if (nv < 2 || nv > DEF_MAX_UNIVERSE || nk < 1 || nk > DEF_MAX_SUBSET || nk >= nv)
        begin
            r.err = 1'b1;
            return r;
        end
        acc = '0;
        if (md == MODE_RANK)
        begin
            cnt = 0;
            for (pos = 0; pos < nv; pos++)
            begin
                if (msk[pos])
                begin
                    cnt++;
                    if (cnt <= nk)
                        acc += pascal[pos][cnt];
                end
            end
            if (cnt != nk || acc > 64'hFFFF_FFFF)
                r.err = 1'b1;
            else
                r.rank = acc[RANK_W-1:0];
        end
        else
        begin
            if ({32'd0, rnk} >= pascal[nv][nk])
            begin
                r.err = 1'b1;
                return r;
            end
            rem = {32'd0, rnk};
            for (int i = nk; i > 0; i--)
            begin
                e = i - 1;
                p = e;
                while (p + 1 < nv && pascal[p+1][e+1] <= rem)
                    p++;
                rem -= pascal[p][e+1];
                acc[p] = 1'b1;
            end
            r.mask = acc;
        end
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        fail_total++;
        if (fail_total <= 10)
            $display("%0t ns checker: %s", $time, msg);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_v <= 7'd7;
            shadow_k <= 5'd3;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_UNIVERSE)
                shadow_v <= cfg_data[UNIVERSE_W-1:0];
            else if (cfg_index == CFG_SUBSET)
                shadow_k <= cfg_data[SUBSET_W-1:0];
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        colex_result_t got;
        colex_result_t want;
        if (!rst_n)
        begin
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                due_results.push_back(colex_convert(shadow_v, shadow_k, mode,
                                                    mask_in, rank_in));
            if (out_valid && out_ready)
            begin
                got.rank = rank_out;
                got.mask = mask_out;
                got.err  = error;
                seen_total++;
                if (got.err)
                    flag_total++;
                if (due_results.size() == 0)
                    log_failure($sformatf("result with none due: rank %h mask %h err %b",
                                          got.rank, got.mask, got.err));
                else
                begin
                    want = due_results.pop_front();
                    if (got.rank !== want.rank || got.mask !== want.mask
                        || got.err !== want.err)
                        log_failure($sformatf({"mismatch: rank %h/%h mask %h/%h ",
                                               "err %b/%b (expected/actual)"},
                                              want.rank, got.rank, want.mask, got.mask,
                                              want.err, got.err));
                end
            end
            outstanding <= due_results.size();
        end
    end

endmodule

@@ tb/tb_subset_rank_unrank.sv @@
// ---------------------------------------------------------------------------
// tb_subset_rank_unrank
// Drives the subset rank/unrank block through directed corner items and
// random phases over many register settings, valid and invalid, with random
// idling on both channels. A checker beside the block judges every result.
// ---------------------------------------------------------------------------
module tb_subset_rank_unrank;
    timeunit 1ns;
    timeprecision 1ps;
    import sru_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_UNIVERSE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic                  mode      = MODE_RANK;
    logic [MASK_W-1:0]     mask_in   = '0;
    logic [RANK_W-1:0]     rank_in   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RANK_W-1:0]     rank_out;
    logic [MASK_W-1:0]     mask_out;
    logic                  error;

    int mismatches;
    int outstanding;
    int checked;
    int flagged;

    // Stimulus bookkeeping
    int in_gap       = 0;
    bit in_calm      = 1'b0;
    int items_sent   = 0;
    int settings_run = 0;
    int settings_bad = 0;

    always #4 clk = ~clk;

    subset_rank_unrank u_dut (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .mode, .mask_in, .rank_in,
        .out_valid, .out_ready, .rank_out, .mask_out, .error
    );

    subset_rank_unrank_checker u_checker (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_ready, .mode, .mask_in, .rank_in,
        .out_valid, .out_ready, .rank_out, .mask_out, .error,
        .mismatches, .outstanding, .checked, .flagged
    );

    // Present one item and hold it until the block takes it. Valid stays up
    // across back-to-back items; drop it only when a gap follows.
    task automatic send_item(input logic md, input logic [MASK_W-1:0] mk,
                             input logic [RANK_W-1:0] rk);
        repeat (in_gap) @(posedge clk);
        in_valid <= 1'b1;
        mode     <= md;
        mask_in  <= mk;
        rank_in  <= rk;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        // Draw the gap before the next item; calm stretches run with none.
        in_gap = in_calm ? 0 : $urandom_range(6);
        if ($urandom_range(31) == 0)
            in_calm = !in_calm;
        if (in_gap != 0)
            in_valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic settle();
        if (in_gap == 0)
            in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    // Write both registers on an idle block. Junk goes into the data bits
    // above the subset size field, which the block must ignore.
    task automatic load_setting(input int v, input int k, output bit ok);
        logic [CFG_DATA_W-1:0] kdata;
        settle();
        kdata      = k[CFG_DATA_W-1:0];
        kdata[6:5] = $urandom_range(3);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_UNIVERSE;
        cfg_data  <= v[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_SUBSET;
        cfg_data  <= kdata;
        @(posedge clk);
        cfg_we    <= 1'b0;
        ok = (v >= 2 && v <= DEF_MAX_UNIVERSE && k >= 1 && k <= DEF_MAX_SUBSET && k < v);
        settings_run++;
        if (!ok)
            settings_bad++;
    endtask

    // Random k-element subset of positions below lim.
    function automatic logic [MASK_W-1:0] pick_subset(input int lim, input int k);
        logic [MASK_W-1:0] m;
        int got;
        int pos;
        m   = '0;
        got = 0;
        while (got < k)
        begin
            pos = $urandom_range(lim - 1);
            if (!m[pos])
            begin
                m[pos] = 1'b1;
                got++;
            end
        end
        return m;
    endfunction

    // One register setting, then n random items. On a valid setting most
    // items are well formed: k-subsets (some packed low so that the rank
    // fits 32 bits) and ranks below C(v,k). The rest are off-by-one subsets,
    // out-of-range ranks and plain noise.
    task automatic run_phase(input int v, input int k, input int n);
        logic [MASK_W-1:0] span;
        logic [MASK_W-1:0] mk;
        logic [COEF_W-1:0] total;
        logic [RANK_W-1:0] rk;
        logic              md;
        bit                ok;
        int                roll;
        int                lim;
        load_setting(v, k, ok);
        span  = '1;
        total = '0;
        if (ok)
        begin
            if (v < MASK_W)
                span = (64'd1 << v) - 1;
            total = 64'd1;
            for (int i = 0; i < k; i++)
                total = total * (v - i) / (i + 1);
        end
        repeat (n)
        begin
            roll = $urandom_range(99);
            md   = $urandom_range(1);
            mk   = {$urandom, $urandom};
            rk   = $urandom;
            if (ok && md == MODE_RANK && roll < 88)
            begin
                lim = (roll < 30) ? $urandom_range(v, k) : v;
                mk  = pick_subset(lim, k);
                if (roll >= 75)
                    mk ^= 64'd1 << $urandom_range(v - 1);
                if (roll[0])
                    mk |= {$urandom, $urandom} & ~span;
            end
            else if (ok && md == MODE_UNRANK && roll < 90 && total <= 64'hFFFF_FFFF)
            begin
                if (roll < 8)
                    rk = total - 1;
                else if (roll < 12)
                    rk = '0;
                else if (roll < 80)
                    rk = {$urandom, $urandom} % total;
                else if (total + 3 <= 64'hFFFF_FFFF)
                    rk = total + $urandom_range(3);
            end
            send_item(md, mk, rk);
        end
    endtask

    // Release ready at random; calm stretches keep it high throughout.
    initial
    begin : result_sink
        int stall;
        bit calm;
        calm = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(6);
            if ($urandom_range(31) == 0)
                calm = !calm;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin : stimulus
        bit ok;
        int v;
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting, v = 7 and k = 3: lowest and highest subsets and
        // ranks, wrong bit counts, and bits above v that must be ignored.
        send_item(MODE_RANK,   64'h7,                   $urandom);
        send_item(MODE_RANK,   64'h70,                  $urandom);
        send_item(MODE_RANK,   64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        send_item(MODE_RANK,   64'h0,                   $urandom);
        send_item(MODE_RANK,   64'hFFFF_FFFF_FFFF_FF95, $urandom);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd0);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd34);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd35);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'hFFFF_FFFF);

        // Largest setting: rank overflow from the top 20 bits, and every
        // 32-bit rank in range.
        load_setting(64, 20, ok);
        send_item(MODE_RANK,   64'h0000_0000_000F_FFFF, $urandom);
        send_item(MODE_RANK,   64'hFFFF_F000_0000_0000, $urandom);
        send_item(MODE_RANK,   64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd0);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'hFFFF_FFFF);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'h5555_AAAA);

        // Smallest universe.
        load_setting(2, 1, ok);
        send_item(MODE_RANK,   64'h1,                   $urandom);
        send_item(MODE_RANK,   64'h2,                   $urandom);
        send_item(MODE_RANK,   64'h3,                   $urandom);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd1);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd2);

        // Single element at the top bit of a full universe.
        load_setting(64, 1, ok);
        send_item(MODE_RANK,   64'h8000_0000_0000_0000, $urandom);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd63);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd64);

        // Subset as large as the universe is an invalid setting.
        load_setting(10, 10, ok);
        send_item(MODE_RANK,   64'h3FF,                 $urandom);
        send_item(MODE_UNRANK, {$urandom, $urandom},    32'd0);

        // Random phases over fixed corners of the setting space.
        run_phase(7, 3, 100);
        run_phase(2, 1, 100);
        run_phase(64, 20, 100);
        run_phase(64, 1, 100);
        run_phase(21, 20, 100);
        run_phase(33, 16, 100);
        run_phase(40, 5, 100);
        run_phase(12, 11, 100);
        run_phase(64, 10, 100);

        // Invalid settings: v too small or too large, k zero, too large or
        // not below v.
        run_phase(0, 3, 10);
        run_phase(1, 1, 10);
        run_phase(100, 5, 10);
        run_phase(30, 0, 10);
        run_phase(30, 25, 10);
        run_phase(16, 16, 10);

        // A few settings drawn at random.
        repeat (4)
        begin
            v = $urandom_range(64, 2);
            k = $urandom_range((v - 1 < DEF_MAX_SUBSET) ? v - 1 : DEF_MAX_SUBSET, 1);
            run_phase(v, k, 80);
        end

        // Drain, then allow the longest walk to show any stray result.
        settle();
        repeat (200) @(posedge clk);

        $display("Sent %0d items under %0d register settings, %0d of them invalid.",
                 items_sent, settings_run + 1, settings_bad);
        $display("Checked %0d results, %0d with the error flag, %0d mismatches.",
                 checked, flagged, mismatches);
        if (mismatches == 0)
            $display("** subset_rank_unrank: PASSED **");
        else
            $display("** subset_rank_unrank: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin : watchdog
        #6ms;
        $display("Timeout with %0d results still due.", outstanding);
        $display("** subset_rank_unrank: FAILED **");
        $finish;
    end

endmodule
